[rtl/ncmtf_pkg.sv]
// Shared types and constants of the neighbor context move-to-front ranker.
`timescale 1ns / 1ps
`default_nettype none
package ncmtf_pkg;

  localparam int MAX_CLASSES_DEF = 64;
  localparam int LABEL_W = 6;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam int RANK_OUT_W = 6;
  localparam int NUM_REFS = 3;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [CFG_W-1:0] count_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_WAITJ,
    ST_SWEEP,
    ST_QREAD,
    ST_QWAIT
  } state_t;

endpackage
`default_nettype wire

[rtl/ncmtf_ifs.sv]
// Request and result channel interfaces of the ranker.
`timescale 1ns / 1ps
`default_nettype none
interface ncmtf_in_if;
  logic                  valid;
  logic                  ready;
  ncmtf_pkg::label_t     upper_label;
  ncmtf_pkg::label_t     left_label;
  ncmtf_pkg::label_t     upright_label;
  logic                  first_row;
  logic                  first_col;
  logic                  last_block_col;
  ncmtf_pkg::label_t     query_label;

  modport source (output valid, upper_label, left_label, upright_label, first_row,
                  first_col, last_block_col, query_label, input ready);
  modport sink (input valid, upper_label, left_label, upright_label, first_row,
                first_col, last_block_col, query_label, output ready);
endinterface

interface ncmtf_out_if;
  logic                                valid;
  logic                                ready;
  logic [ncmtf_pkg::RANK_OUT_W-1:0]    query_rank;

  modport source (output valid, query_rank, input ready);
  modport sink (input valid, query_rank, output ready);
endinterface
`default_nettype wire

[rtl/ncmtf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ncmtf_ram #(
  parameter int WIDTH = ncmtf_pkg::LABEL_W,
  parameter int DEPTH = ncmtf_pkg::MAX_CLASSES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/ncmtf_seq.sv]
// Sequencer that walks the rank memory for each move-to-front update and the query read.
`timescale 1ns / 1ps
`default_nettype none
module ncmtf_seq #(
  parameter int MAX_CLASSES = ncmtf_pkg::MAX_CLASSES_DEF,
  localparam int AW = $clog2(MAX_CLASSES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ncmtf_pkg::count_t n_classes,
  ncmtf_in_if.sink               in_chan,
  ncmtf_out_if.source            out_chan,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [AW-1:0]          mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  wire logic [AW-1:0]     mem_rdata
);

  ncmtf_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [1:0] mv_r, mv_nxt;
  ncmtf_pkg::label_t ref_r [ncmtf_pkg::NUM_REFS];
  ncmtf_pkg::label_t ref_nxt [ncmtf_pkg::NUM_REFS];
  ncmtf_pkg::label_t q_r, q_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ncmtf_pkg::RANK_OUT_W-1:0] out_rank_r, out_rank_nxt;

  ncmtf_pkg::label_t cur_label;
  ncmtf_pkg::label_t sel [ncmtf_pkg::NUM_REFS];
  logic label_ok, q_ok, sweep_last, out_free, init_last;

  assign cur_label = ref_r[mv_r];
  assign label_ok = {1'b0, cur_label} < n_classes;
  assign q_ok = {1'b0, q_r} < n_classes;
  assign sweep_last = int'(idx_r) == int'(n_classes) - 1;
  assign init_last = idx_r == AW'(MAX_CLASSES - 1);
  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.query_rank = out_rank_r;

  always_comb begin
    if (in_chan.first_row) begin
      sel[0] = in_chan.first_col ? '0 : in_chan.left_label;
      sel[1] = sel[0];
      sel[2] = sel[0];
    end else begin
      sel[0] = in_chan.upper_label;
      sel[1] = in_chan.first_col ? in_chan.upper_label : in_chan.left_label;
      sel[2] = in_chan.last_block_col ? in_chan.upper_label : in_chan.upright_label;
      if (sel[1] == sel[2]) begin
        sel[2] = in_chan.upper_label;
        sel[0] = sel[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncmtf_pkg::ST_INIT;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r <= mv_nxt;
    ref_r <= ref_nxt;
    q_r <= q_nxt;
    j_r <= j_nxt;
    out_rank_r <= out_rank_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    mv_nxt = mv_r;
    ref_nxt = ref_r;
    q_nxt = q_r;
    j_nxt = j_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_rank_nxt = out_rank_r;
    in_chan.ready = 1'b0;
    mem_we = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_raddr = AW'(cur_label);
    unique case (state_r)
      ncmtf_pkg::ST_INIT: begin
        mem_we = 1'b1;
        mem_wdata = idx_r;
        if (init_last) begin
          idx_nxt = '0;
          state_nxt = ncmtf_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ncmtf_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          ref_nxt = sel;
          q_nxt = in_chan.query_label;
          mv_nxt = 2'd2;
          state_nxt = ncmtf_pkg::ST_LOOK;
        end
      end
      ncmtf_pkg::ST_LOOK: begin
        if (label_ok) begin
          state_nxt = ncmtf_pkg::ST_WAITJ;
        end else if (mv_r == 2'd0) begin
          state_nxt = ncmtf_pkg::ST_QREAD;
        end else begin
          mv_nxt = mv_r - 1'b1;
        end
      end
      ncmtf_pkg::ST_WAITJ: begin
        j_nxt = mem_rdata;
        if (mem_rdata == '0) begin
          if (mv_r == 2'd0) begin
            state_nxt = ncmtf_pkg::ST_QREAD;
          end else begin
            mv_nxt = mv_r - 1'b1;
            state_nxt = ncmtf_pkg::ST_LOOK;
          end
        end else begin
          mem_raddr = '0;
          idx_nxt = '0;
          state_nxt = ncmtf_pkg::ST_SWEEP;
        end
      end
      ncmtf_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
        mem_raddr = idx_r + 1'b1;
        if (idx_r == AW'(cur_label)) begin
          mem_wdata = '0;
        end else if (mem_rdata < j_r) begin
          mem_wdata = mem_rdata + 1'b1;
        end
        if (sweep_last) begin
          idx_nxt = '0;
          if (mv_r == 2'd0) begin
            state_nxt = ncmtf_pkg::ST_QREAD;
          end else begin
            mv_nxt = mv_r - 1'b1;
            state_nxt = ncmtf_pkg::ST_LOOK;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ncmtf_pkg::ST_QREAD: begin
        mem_raddr = AW'(q_r);
        if (q_ok) begin
          state_nxt = ncmtf_pkg::ST_QWAIT;
        end else if (out_free) begin
          out_rank_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt = ncmtf_pkg::ST_IDLE;
        end
      end
      ncmtf_pkg::ST_QWAIT: begin
        mem_raddr = AW'(q_r);
        if (out_free) begin
          out_rank_nxt = ncmtf_pkg::RANK_OUT_W'(mem_rdata);
          out_valid_nxt = 1'b1;
          state_nxt = ncmtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ncmtf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/neighbor_context_mtf_ranker_core.sv]
// Top level of the neighbor context move-to-front ranker.
//
// Channel   Direction  Handshake          Contents
// in_chan   input      valid/ready        three neighbor labels, position flags, query label
// out_chan  output     valid/ready        rank of the query label after the update
// cfg_      input      write enable only  active class count
//
// Each reference that moves costs a rank lookup plus one sweep through the first n entries of
// the rank memory, where n is the active class count, using its single read and single write
// port; the query read follows the updates. After reset a clearing pass over all MAX_CLASSES
// entries loads the identity ranks before the first request is taken. A stalled result stays in
// the output register while the next request is accepted; the query of that request waits until
// the register is free.
`timescale 1ns / 1ps
`default_nettype none
module neighbor_context_mtf_ranker_core #(
  parameter int MAX_CLASSES = ncmtf_pkg::MAX_CLASSES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [ncmtf_pkg::CFG_W-1:0] cfg_wdata,
  ncmtf_in_if.sink                       in_chan,
  ncmtf_out_if.source                    out_chan
);

  localparam int AW = $clog2(MAX_CLASSES);

  ncmtf_pkg::count_t cfg_r;
  ncmtf_pkg::count_t n_classes;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ncmtf_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign n_classes = (int'(cfg_r) > MAX_CLASSES) ? ncmtf_pkg::CFG_W'(MAX_CLASSES) : cfg_r;

  ncmtf_seq #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_classes (n_classes),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ncmtf_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_CLASSES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
